// File: hw/rtl/prb_pkg.sv
// Shared types and constants for the polynomial bisection root finder.
package prb_pkg;

    localparam int CoefW = 32;
    localparam int TolW  = 31;
    localparam int CapW  = 8;
    localparam int IdxW  = 3;

    localparam logic [IdxW-1:0] CFG_COEF_3    = 3'd0;
    localparam logic [IdxW-1:0] CFG_COEF_2    = 3'd1;
    localparam logic [IdxW-1:0] CFG_COEF_1    = 3'd2;
    localparam logic [IdxW-1:0] CFG_COEF_0    = 3'd3;
    localparam logic [IdxW-1:0] CFG_TOLERANCE = 3'd4;
    localparam logic [IdxW-1:0] CFG_ITER_CAP  = 3'd5;

    localparam logic signed [CoefW-1:0] COEF_3_RST = 32'sd0;
    localparam logic signed [CoefW-1:0] COEF_2_RST = -32'sd327680;
    localparam logic signed [CoefW-1:0] COEF_1_RST = 32'sd209715;
    localparam logic signed [CoefW-1:0] COEF_0_RST = 32'sd491520;
    localparam logic [TolW-1:0]         TOL_RST    = 31'd66;
    localparam logic [CapW-1:0]         CAP_RST    = 8'd48;

    typedef struct packed {
        logic signed [CoefW-1:0] lower_end;
        logic signed [CoefW-1:0] upper_end;
    } t_prb_in;

    typedef struct packed {
        logic signed [CoefW-1:0] root;
        logic                    converged;
        logic [CapW-1:0]         iterations_used;
    } t_prb_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FA,
        S_MID,
        S_FM,
        S_CHK,
        S_DONE
    } t_prb_state;

    typedef enum logic [1:0] {
        H_IDLE,
        H_MUL,
        H_RND,
        H_ADD
    } t_hrn_state;

endpackage

// File: hw/rtl/poly_root_bisection.sv
// Top level: bisection root finder for a cubic in signed Q16.16.
// One request [lower_end, upper_end] gives one result. Each polynomial value
// comes from a Horner unit with one shared 32x32 multiplier that steps through
// multiply, round and add for each coefficient. An item evaluates f(lower_end)
// and then one midpoint per halving, at most iteration_cap midpoint
// evaluations (one when the cap is zero). The input is ready only while
// no item is in work; a finished result waits in the output register.
module poly_root_bisection #(
    parameter int NUM_COEFFS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  prb_pkg::t_prb_in              i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output prb_pkg::t_prb_out             o_out,
    input  logic                          i_cfg_we,
    input  logic [prb_pkg::IdxW-1:0]      i_cfg_index,
    input  logic [prb_pkg::CoefW-1:0]     i_cfg_data
);
    import prb_pkg::*;

    t_prb_state               r_state, n_state;
    logic signed [CoefW-1:0]  r_coef [4];
    logic [TolW-1:0]          r_tol;
    logic [CapW-1:0]          r_cap;
    logic signed [CoefW-1:0]  r_a, r_b, r_fa, r_fm, r_mid;
    logic [CapW-1:0]          r_iter;
    logic                     r_conv;
    logic                     r_out_valid;
    t_prb_out                 r_out;

    logic                     w_accept;
    logic                     w_hrn_start;
    logic signed [CoefW-1:0]  w_hrn_x;
    logic                     w_hrn_done;
    logic signed [CoefW-1:0]  w_hrn_value;
    logic signed [CoefW:0]    w_ab_sum;
    logic signed [CoefW-1:0]  w_mid;
    logic [CoefW:0]           w_fm_abs;
    logic                     w_tol_met;
    logic [CapW-1:0]          w_cap_m1;
    logic                     w_cap_hit;
    logic                     w_flip;
    logic                     w_out_free;

    prb_horner #(
        .NUM_COEFFS (NUM_COEFFS)
    ) u_horner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_hrn_start),
        .i_x     (w_hrn_x),
        .i_coef  (r_coef),
        .o_done  (w_hrn_done),
        .o_value (w_hrn_value)
    );

    always_comb begin
        w_ab_sum   = {r_a[CoefW-1], r_a} + {r_b[CoefW-1], r_b};
        w_mid      = w_ab_sum[CoefW:1];
        w_fm_abs   = r_fm[CoefW-1] ? (CoefW+1)'(-{r_fm[CoefW-1], r_fm})
                                   : {1'b0, r_fm};
        w_tol_met  = w_fm_abs < {2'b00, r_tol};
        w_cap_m1   = (r_cap == '0) ? '0 : r_cap - 8'd1;
        w_cap_hit  = r_iter >= w_cap_m1;
        w_flip     = (r_fa[CoefW-1] && !r_fm[CoefW-1] && (r_fm != '0)) ||
                     (!r_fa[CoefW-1] && (r_fa != '0) && r_fm[CoefW-1]);
        w_out_free = !r_out_valid || i_out_ready;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_FA;
            S_FA:   if (w_hrn_done) n_state = S_MID;
            S_MID:  n_state = S_FM;
            S_FM:   if (w_hrn_done) n_state = S_CHK;
            S_CHK:  n_state = (w_tol_met || w_cap_hit) ? S_DONE : S_MID;
            S_DONE: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        w_accept    = i_in_valid && o_in_ready;
        w_hrn_start = w_accept || (r_state == S_MID);
        w_hrn_x     = (r_state == S_IDLE) ? i_in.lower_end : w_mid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[0] <= COEF_3_RST;
            r_coef[1] <= COEF_2_RST;
            r_coef[2] <= COEF_1_RST;
            r_coef[3] <= COEF_0_RST;
            r_tol     <= TOL_RST;
            r_cap     <= CAP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_COEF_3:    r_coef[0] <= i_cfg_data;
                CFG_COEF_2:    r_coef[1] <= i_cfg_data;
                CFG_COEF_1:    r_coef[2] <= i_cfg_data;
                CFG_COEF_0:    r_coef[3] <= i_cfg_data;
                CFG_TOLERANCE: r_tol     <= i_cfg_data[TolW-1:0];
                CFG_ITER_CAP:  r_cap     <= i_cfg_data[CapW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_iter      <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) r_iter <= '0;
            if ((r_state == S_CHK) && !w_tol_met && !w_cap_hit) r_iter <= r_iter + 8'd1;
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a <= i_in.lower_end;
            r_b <= i_in.upper_end;
        end
        if ((r_state == S_FA) && w_hrn_done) r_fa <= w_hrn_value;
        if (r_state == S_MID) r_mid <= w_mid;
        if ((r_state == S_FM) && w_hrn_done) r_fm <= w_hrn_value;
        if (r_state == S_CHK) begin
            r_conv <= w_tol_met;
            if (!w_tol_met && !w_cap_hit) begin
                if (w_flip) begin
                    r_b <= r_mid;
                end else begin
                    r_a  <= r_mid;
                    r_fa <= r_fm;
                end
            end
        end
        if ((r_state == S_DONE) && w_out_free) begin
            r_out.root            <= r_mid;
            r_out.converged       <= r_conv;
            r_out.iterations_used <= r_iter;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_FA))
        else $error("accepted request did not start evaluation");
    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_iter <= w_cap_m1))
        else $error("halving count beyond cap");
    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hrn_done |-> (r_state == S_FA || r_state == S_FM))
        else $error("evaluation finished in wrong state");
    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside done state");

endmodule

// File: hw/rtl/prb_horner.sv
// Horner evaluator with one shared multiplier, rounding and saturation.
module prb_horner #(
    parameter int NUM_COEFFS = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [prb_pkg::CoefW-1:0]      i_x,
    input  logic signed [prb_pkg::CoefW-1:0]      i_coef [4],
    output logic                                  o_done,
    output logic signed [prb_pkg::CoefW-1:0]      o_value
);
    import prb_pkg::*;

    localparam logic [1:0] IdxFirst = 2'(4 - NUM_COEFFS);
    localparam logic [1:0] IdxLast  = 2'd3;
    localparam logic signed [47:0] RndMax = 48'sh0000_7FFF_FFFF;
    localparam logic signed [47:0] RndMin = -48'sh0000_8000_0000;

    t_hrn_state               r_state, n_state;
    logic signed [CoefW-1:0]  r_x;
    logic signed [CoefW-1:0]  r_sum;
    logic signed [63:0]       r_prod;
    logic [1:0]               r_idx;
    logic                     r_done;

    logic signed [63:0]       w_rnd_sum;
    logic signed [47:0]       w_rnd;
    logic signed [CoefW-1:0]  w_rnd_sat;
    logic signed [CoefW:0]    w_add;
    logic signed [CoefW-1:0]  w_add_sat;
    logic                     w_last;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            H_IDLE: if (i_start) n_state = H_MUL;
            H_MUL:  n_state = H_RND;
            H_RND:  n_state = H_ADD;
            H_ADD:  n_state = (r_idx == IdxLast) ? H_IDLE : H_MUL;
            default: n_state = H_IDLE;
        endcase
    end

    always_comb begin
        w_last    = (r_state == H_ADD) && (r_idx == IdxLast);
        w_rnd_sum = r_prod + 64'sd32768;
        w_rnd     = w_rnd_sum[63:16];
        if (w_rnd > RndMax) begin
            w_rnd_sat = 32'sh7FFF_FFFF;
        end else if (w_rnd < RndMin) begin
            w_rnd_sat = -32'sh8000_0000;
        end else begin
            w_rnd_sat = w_rnd[31:0];
        end
        w_add = {r_sum[CoefW-1], r_sum} + {i_coef[r_idx][CoefW-1], i_coef[r_idx]};
        if (w_add[CoefW] != w_add[CoefW-1]) begin
            w_add_sat = w_add[CoefW] ? -32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            w_add_sat = w_add[CoefW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            H_IDLE: if (i_start) begin
                r_x   <= i_x;
                r_sum <= '0;
                r_idx <= IdxFirst;
            end
            H_MUL: r_prod <= r_sum * r_x;
            H_RND: r_sum  <= w_rnd_sat;
            H_ADD: begin
                r_sum <= w_add_sat;
                if (!w_last) r_idx <= r_idx + 2'd1;
            end
            default: ;
        endcase
    end

    assign o_done  = r_done;
    assign o_value = r_sum;

    a_done_after_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state == H_ADD))
        else $error("done without final add");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == H_MUL) |-> $past(r_state == H_IDLE || r_state == H_ADD))
        else $error("multiply step out of sequence");
    a_rnd_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == H_RND) |-> $past(r_state == H_MUL))
        else $error("round step out of sequence");

endmodule
